// ===== design/gcr_pkg.sv =====
`timescale 1ns / 1ps
package gcr_pkg;

  localparam int AXES    = 4;
  localparam int RAW_W   = 12;
  localparam int GAIN_W  = 10;
  localparam int AXIS_W  = 20;
  localparam int BTN_W   = 64;
  localparam int BIT_W   = 7;
  localparam int STEP_W  = 19;
  localparam int PROD_W  = 22;
  localparam int QUO_W   = 15;

  localparam logic [RAW_W-1:0] CENTER = 12'd2048;

  // truncating divide by 100 for products below 2**21: (p * RECIP) >> RECIP_SHIFT
  localparam logic [PROD_W-1:0] RECIP_100   = 22'd2684355;
  localparam int                RECIP_SHIFT = 28;

  localparam logic [7:0] REPORT_ID_OK = 8'h01;

  // configuration register indexes
  localparam logic [2:0] REG_TUNING_POS  = 3'd0;
  localparam logic [2:0] REG_TUNING_NEG  = 3'd1;
  localparam logic [2:0] REG_DEADZONE    = 3'd2;
  localparam logic [2:0] REG_SCALE       = 3'd3;
  localparam logic [2:0] REG_STEP_LIMIT  = 3'd4;
  localparam logic [2:0] REG_SWITCH_BIT  = 3'd5;
  localparam logic [2:0] REG_LCLICK_BIT  = 3'd6;
  localparam logic [2:0] REG_RCLICK_BIT  = 3'd7;

  // hat codes
  localparam logic [7:0] HAT_N  = 8'd0;
  localparam logic [7:0] HAT_NE = 8'd1;
  localparam logic [7:0] HAT_E  = 8'd2;
  localparam logic [7:0] HAT_SE = 8'd3;
  localparam logic [7:0] HAT_S  = 8'd4;
  localparam logic [7:0] HAT_SW = 8'd5;
  localparam logic [7:0] HAT_W  = 8'd6;
  localparam logic [7:0] HAT_NW = 8'd7;

  // per-report data that travels beside the axis lanes
  typedef struct packed {
    logic             switch_held;
    logic [BTN_W-1:0] buttons;
    logic             up;
    logic             right;
    logic             down;
    logic             left;
  } side_t;

endpackage

// ===== design/gcr_lane.sv =====
`timescale 1ns / 1ps
module gcr_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic                                invert,
  input  logic [gcr_pkg::RAW_W-1:0]           raw,
  input  logic [gcr_pkg::GAIN_W-1:0]          gain_pos,
  input  logic [gcr_pkg::GAIN_W-1:0]          gain_neg,
  input  logic [gcr_pkg::RAW_W-1:0]           deadzone,
  input  logic [3:0]                          scale,
  output logic [gcr_pkg::AXIS_W-1:0]          axis
);

  // stage 1: centre, deadzone, gain product
  logic [gcr_pkg::RAW_W-1:0]  mag;
  logic [gcr_pkg::RAW_W-1:0]  mag_dz;
  logic                       neg;
  logic [gcr_pkg::GAIN_W-1:0] gain;
  logic [gcr_pkg::PROD_W-1:0] prod1;

  logic [gcr_pkg::PROD_W-1:0] s1_prod;
  logic [gcr_pkg::RAW_W-1:0]  s1_mag;
  logic                       s1_neg;
  logic                       s1_gz;

  // stage 2: reciprocal multiply for the divide by 100
  logic [2*gcr_pkg::PROD_W-1:0] prod2;
  logic [gcr_pkg::QUO_W-1:0]    s2_quo;
  logic [gcr_pkg::RAW_W-1:0]    s2_mag;
  logic                         s2_neg;
  logic                         s2_gz;

  // stage 3: optional scale and sign
  logic [gcr_pkg::QUO_W-1:0]    mag3;
  logic [3:0]                   sc;
  logic [gcr_pkg::AXIS_W-2:0]   prod3;
  logic [gcr_pkg::AXIS_W-1:0]   val3;

  always_comb begin
    if (raw >= gcr_pkg::CENTER) begin
      mag = raw - gcr_pkg::CENTER;
    end else begin
      mag = gcr_pkg::CENTER - raw;
    end
    neg    = invert ? (raw > gcr_pkg::CENTER) : (raw < gcr_pkg::CENTER);
    mag_dz = (deadzone != '0 && mag < deadzone) ? '0 : mag;
    gain   = neg ? gain_neg : gain_pos;
    prod1  = {{(gcr_pkg::PROD_W-gcr_pkg::RAW_W){1'b0}}, mag_dz}
           * {{(gcr_pkg::PROD_W-gcr_pkg::GAIN_W){1'b0}}, gain};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod <= prod1;
      s1_mag  <= mag_dz;
      s1_neg  <= neg;
      s1_gz   <= (gain == '0);
    end
  end

  assign prod2 = {{gcr_pkg::PROD_W{1'b0}}, s1_prod}
               * {{gcr_pkg::PROD_W{1'b0}}, gcr_pkg::RECIP_100};

  always_ff @(posedge clk) begin
    if (en) begin
      s2_quo <= prod2[gcr_pkg::RECIP_SHIFT +: gcr_pkg::QUO_W];
      s2_mag <= s1_mag;
      s2_neg <= s1_neg;
      s2_gz  <= s1_gz;
    end
  end

  always_comb begin
    mag3  = s2_gz ? {{(gcr_pkg::QUO_W-gcr_pkg::RAW_W){1'b0}}, s2_mag} : s2_quo;
    sc    = (scale == 4'd0) ? 4'd1 : scale;
    prod3 = {4'b0, mag3} * {{(gcr_pkg::AXIS_W-5){1'b0}}, sc};
    val3  = s2_neg ? (-{1'b0, prod3}) : {1'b0, prod3};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axis <= val3;
    end
  end

endmodule

// ===== design/gcr_merge.sv =====
`timescale 1ns / 1ps
module gcr_merge (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  logic                                         load_valid,
  input  logic [gcr_pkg::AXES-1:0][gcr_pkg::AXIS_W-1:0] axes,
  input  gcr_pkg::side_t                               side,
  input  logic [gcr_pkg::STEP_W-1:0]                   step_limit,
  output logic                                         out_valid,
  output logic [gcr_pkg::AXIS_W-1:0]                   left_x,
  output logic [gcr_pkg::AXIS_W-1:0]                   left_y,
  output logic [gcr_pkg::AXIS_W-1:0]                   right_x,
  output logic [gcr_pkg::AXIS_W-1:0]                   right_y,
  output logic [gcr_pkg::BTN_W-1:0]                    buttons_out,
  output logic                                         dpad_up,
  output logic                                         dpad_right,
  output logic                                         dpad_down,
  output logic                                         dpad_left
);

  logic [gcr_pkg::AXES-1:0][gcr_pkg::AXIS_W-1:0] reported;
  logic [gcr_pkg::AXES-1:0][gcr_pkg::AXIS_W-1:0] previous;
  logic [gcr_pkg::AXES-1:0][gcr_pkg::AXIS_W-1:0] filt;
  logic [gcr_pkg::AXES-1:0]                      drop;
  logic                                          filt_en;
  logic                                          load;

  assign filt_en = (step_limit != '0);
  assign load    = en && load_valid;

  // spike filter, one comparator pair per axis
  always_comb begin
    logic signed [gcr_pkg::AXIS_W:0] dr;
    logic signed [gcr_pkg::AXIS_W:0] dp;
    logic        [gcr_pkg::AXIS_W:0] adr;
    logic        [gcr_pkg::AXIS_W:0] adp;
    for (int i = 0; i < gcr_pkg::AXES; i++) begin
      dr = $signed({axes[i][gcr_pkg::AXIS_W-1], axes[i]})
         - $signed({reported[i][gcr_pkg::AXIS_W-1], reported[i]});
      dp = $signed({axes[i][gcr_pkg::AXIS_W-1], axes[i]})
         - $signed({previous[i][gcr_pkg::AXIS_W-1], previous[i]});
      adr = dr[gcr_pkg::AXIS_W] ? unsigned'(-dr) : unsigned'(dr);
      adp = dp[gcr_pkg::AXIS_W] ? unsigned'(-dp) : unsigned'(dp);
      drop[i] = (adr > {2'b0, step_limit}) && (adp > {2'b0, step_limit});
      filt[i] = (filt_en && drop[i]) ? reported[i] : axes[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reported <= '0;
      previous <= '0;
    end else if (load && filt_en) begin
      for (int i = 0; i < gcr_pkg::AXES; i++) begin
        previous[i] <= axes[i];
        if (!drop[i]) begin
          reported[i] <= axes[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= load_valid;
    end
  end

  // stick switch moves the left stick across
  always_ff @(posedge clk) begin
    if (load) begin
      left_x      <= side.switch_held ? '0 : filt[0];
      left_y      <= side.switch_held ? '0 : filt[1];
      right_x     <= side.switch_held ? filt[0] : filt[2];
      right_y     <= side.switch_held ? filt[1] : filt[3];
      buttons_out <= side.buttons;
      dpad_up     <= side.up;
      dpad_right  <= side.right;
      dpad_down   <= side.down;
      dpad_left   <= side.left;
    end
  end

`ifndef SYNTHESIS
  a_state_frozen: assert property (@(posedge clk) disable iff (rst)
    !filt_en |=> ($stable(reported) && $stable(previous)))
    else $error("filter state changed while filter disabled");
`endif

endmodule

// ===== design/gamepad_report_conditioner_unit.sv =====
`timescale 1ns / 1ps
// channel   signals                                        direction
// input     in_valid / in_ready, report fields             into the block
// output    out_valid / out_ready, conditioned fields      out of the block
// config    cfg_we, cfg_index, cfg_data                    into the block
//
// one report per cycle while the output register is free; a result passes through
// three lane stages, then the merge/output register
// the whole pipeline advances together whenever the output register is free
// reports with a wrong id or short length are dropped at the input
// synchronous reset restores the register defaults and clears the filter history
module gamepad_report_conditioner_unit (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [39:0]                         cfg_data,
  // report in
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          report_id,
  input  logic                                report_full_length,
  input  logic [gcr_pkg::RAW_W-1:0]           left_x_raw,
  input  logic [gcr_pkg::RAW_W-1:0]           left_y_raw,
  input  logic [gcr_pkg::RAW_W-1:0]           right_x_raw,
  input  logic [gcr_pkg::RAW_W-1:0]           right_y_raw,
  input  logic [gcr_pkg::BTN_W-1:0]           button_word,
  input  logic [7:0]                          hat_code,
  // result out
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gcr_pkg::AXIS_W-1:0]   left_x,
  output logic signed [gcr_pkg::AXIS_W-1:0]   left_y,
  output logic signed [gcr_pkg::AXIS_W-1:0]   right_x,
  output logic signed [gcr_pkg::AXIS_W-1:0]   right_y,
  output logic [gcr_pkg::BTN_W-1:0]           buttons_out,
  output logic                                dpad_up,
  output logic                                dpad_right,
  output logic                                dpad_down,
  output logic                                dpad_left
);

  // configuration registers
  logic [4*gcr_pkg::GAIN_W-1:0] tuning_positive;
  logic [4*gcr_pkg::GAIN_W-1:0] tuning_negative;
  logic [gcr_pkg::RAW_W-1:0]    deadzone;
  logic [3:0]                   scale;
  logic [gcr_pkg::STEP_W-1:0]   step_limit;
  logic [gcr_pkg::BIT_W-1:0]    switch_bit;
  logic [gcr_pkg::BIT_W-1:0]    left_click_bit;
  logic [gcr_pkg::BIT_W-1:0]    right_click_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      tuning_positive <= {4{10'd200}};
      tuning_negative <= {4{10'd200}};
      deadzone        <= 12'd64;
      scale           <= 4'd2;
      step_limit      <= '0;
      switch_bit      <= 7'd64;
      left_click_bit  <= 7'd64;
      right_click_bit <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        gcr_pkg::REG_TUNING_POS: tuning_positive <= cfg_data;
        gcr_pkg::REG_TUNING_NEG: tuning_negative <= cfg_data;
        gcr_pkg::REG_DEADZONE:   deadzone        <= cfg_data[gcr_pkg::RAW_W-1:0];
        gcr_pkg::REG_SCALE:      scale           <= cfg_data[3:0];
        gcr_pkg::REG_STEP_LIMIT: step_limit      <= cfg_data[gcr_pkg::STEP_W-1:0];
        gcr_pkg::REG_SWITCH_BIT: switch_bit      <= cfg_data[gcr_pkg::BIT_W-1:0];
        gcr_pkg::REG_LCLICK_BIT: left_click_bit  <= cfg_data[gcr_pkg::BIT_W-1:0];
        gcr_pkg::REG_RCLICK_BIT: right_click_bit <= cfg_data[gcr_pkg::BIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: every stage moves when the output register can take data
  logic adv;
  logic accept;
  logic report_ok;
  logic v1, v2, v3;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign accept    = in_valid && in_ready;
  assign report_ok = (report_id == gcr_pkg::REPORT_ID_OK) && report_full_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= accept && report_ok;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // buttons and hat are settled at the input and ride beside the lanes
  gcr_pkg::side_t side_in;
  gcr_pkg::side_t side1, side2, side3;

  always_comb begin
    logic clicks_on;
    side_in             = '0;
    side_in.switch_held = !switch_bit[gcr_pkg::BIT_W-1]
                        && button_word[switch_bit[gcr_pkg::BIT_W-2:0]];
    clicks_on           = !left_click_bit[gcr_pkg::BIT_W-1]
                        && !right_click_bit[gcr_pkg::BIT_W-1];
    side_in.buttons     = button_word;
    if (side_in.switch_held && clicks_on) begin
      // left click folds into right click; same bit named twice ends cleared
      if (button_word[left_click_bit[gcr_pkg::BIT_W-2:0]]) begin
        side_in.buttons[right_click_bit[gcr_pkg::BIT_W-2:0]] = 1'b1;
        side_in.buttons[left_click_bit[gcr_pkg::BIT_W-2:0]]  = 1'b0;
      end else begin
        side_in.buttons[right_click_bit[gcr_pkg::BIT_W-2:0]] = 1'b0;
      end
    end
    side_in.up    = (hat_code == gcr_pkg::HAT_N)  || (hat_code == gcr_pkg::HAT_NE)
                 || (hat_code == gcr_pkg::HAT_NW);
    side_in.right = (hat_code == gcr_pkg::HAT_NE) || (hat_code == gcr_pkg::HAT_E)
                 || (hat_code == gcr_pkg::HAT_SE);
    side_in.down  = (hat_code == gcr_pkg::HAT_SE) || (hat_code == gcr_pkg::HAT_S)
                 || (hat_code == gcr_pkg::HAT_SW);
    side_in.left  = (hat_code == gcr_pkg::HAT_SW) || (hat_code == gcr_pkg::HAT_W)
                 || (hat_code == gcr_pkg::HAT_NW);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1 <= side_in;
      side2 <= side1;
      side3 <= side2;
    end
  end

  // four axis lanes; the left stick is inverted
  logic [gcr_pkg::AXES-1:0][gcr_pkg::RAW_W-1:0]  raws;
  logic [gcr_pkg::AXES-1:0]                      inv;
  logic [gcr_pkg::AXES-1:0][gcr_pkg::AXIS_W-1:0] axes;

  assign raws = {right_y_raw, right_x_raw, left_y_raw, left_x_raw};
  assign inv  = 4'b0011;

  for (genvar g = 0; g < gcr_pkg::AXES; g++) begin : g_lane
    gcr_lane u_lane (
      .clk      (clk),
      .en       (adv),
      .invert   (inv[g]),
      .raw      (raws[g]),
      .gain_pos (tuning_positive[g*gcr_pkg::GAIN_W +: gcr_pkg::GAIN_W]),
      .gain_neg (tuning_negative[g*gcr_pkg::GAIN_W +: gcr_pkg::GAIN_W]),
      .deadzone (deadzone),
      .scale    (scale),
      .axis     (axes[g])
    );
  end

  // spike filter, stick switch and output register
  logic [gcr_pkg::AXIS_W-1:0] lx, ly, rx, ry;

  gcr_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .load_valid  (v3),
    .axes        (axes),
    .side        (side3),
    .step_limit  (step_limit),
    .out_valid   (out_valid),
    .left_x      (lx),
    .left_y      (ly),
    .right_x     (rx),
    .right_y     (ry),
    .buttons_out (buttons_out),
    .dpad_up     (dpad_up),
    .dpad_right  (dpad_right),
    .dpad_down   (dpad_down),
    .dpad_left   (dpad_left)
  );

  assign left_x  = $signed(lx);
  assign left_y  = $signed(ly);
  assign right_x = $signed(rx);
  assign right_y = $signed(ry);

`ifndef SYNTHESIS
  a_drop_bad: assert property (@(posedge clk) disable iff (rst)
    (accept && !report_ok) |=> !v1)
    else $error("rejected report entered the pipeline");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (v1 && !adv) |=> v1)
    else $error("stage one item lost under stall");

  a_land_out: assert property (@(posedge clk) disable iff (rst)
    (v3 && !out_valid) |=> out_valid)
    else $error("finished item did not reach the output register");
`endif

endmodule
